// File: hdl/vpa_pkg.sv
// Package for the variable partition allocator: field structs, codes, defaults.
// No dependencies.
`default_nettype none
package vpa_pkg;
    localparam int MaxSegmentsDef = 64;
    localparam int AddrBitsDef    = 16;
    localparam int IdBitsDef      = 8;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_NO_OWNR = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic CFG_MEM_SIZE = 1'b0;
    localparam logic CFG_POLICY   = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  process_id;
        logic [15:0] request_size;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] start_address;
        logic [15:0] segment_length;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RD_NEXT, S_RD_PREV, S_MERGE,
        S_SHIFT_RD, S_SHIFT_WR, S_FINISH
    } t_state;
endpackage
`default_nettype wire

// File: hdl/variable_partition_allocator.sv
// Variable partition allocator: segment table in one synchronous memory,
// scanned and shifted by a sequencer. Depends on vpa_pkg.
`default_nettype none
// One request at a time: start with busy low takes a beat. busy stays high
// until the single result beat appears on o_rsp with o_done for one cycle, and
// the receiver cannot stall. The scan reads one table entry per cycle. First
// fit and release stop at the match; best and worst fit read all valid entries.
// A failed request or an allocate that needs no split finishes after the scan.
// A split moves every later entry up one place, reading it in S_SHIFT_RD and
// writing it in S_SHIFT_WR, and then writes the new free entry. A release
// reads both neighbors (S_RD_NEXT, S_RD_PREV), writes the merged or freed
// entry in S_MERGE and, when a neighbor was merged, moves later entries down.
// The slowest case is a best or worst fit split of entry 0. busy falls in the
// cycle in which o_done is high, so the next beat can be taken then. After
// reset or a memory_size write the table is ready at once (a fill count marks
// valid entries).
module variable_partition_allocator
    import vpa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MaxSegmentsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire t_req        i_req,
    output logic             busy,
    output logic             o_done,
    output t_rsp             o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEGMENTS);

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] len;
        logic        used;
        logic [7:0]  owner;
    } t_ent;

    // segment table
    t_ent         mem [MAX_SEGMENTS];
    logic         we;
    logic [IW-1:0] waddr, raddr;
    t_ent         wdata, rdata;
    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [15:0]   r_msize;
    logic [1:0]    r_pol;
    t_req          r_req, n_req;
    logic [CW-1:0] r_i, n_i;        // scan / shift index
    logic          r_found, n_found;
    logic [IW-1:0] r_pick, n_pick;
    t_ent          r_pe, n_pe;      // picked entry
    t_ent          r_nx, n_nx;      // preceding entry
    logic          r_nxok, n_nxok;
    logic          r_mgn, n_mgn;    // merged with next
    t_ent          r_sh, n_sh;      // entry being shifted
    logic          r_up, n_up;      // shift direction: open gap
    logic [CW-1:0] r_end, n_end;
    t_rsp          r_rsp, n_rsp;
    logic          r_done, n_done;
    logic          r_init, n_init;  // entry 0 must read as a fresh segment

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // entry 0 override after reset or size write
    t_ent rd;
    logic rd0;
    logic [IW-1:0] r_raddr;
    always_ff @(posedge i_clk) r_raddr <= raddr;
    assign rd0 = r_init && (r_raddr == '0);
    always_comb begin
        rd = rdata;
        if (rd0) rd = '{start: 16'd0, len: r_msize, used: 1'b0, owner: 8'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= CW'(1);
            r_msize <= 16'hFFFF;
            r_pol   <= POL_FIRST;
            r_done  <= 1'b0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            // a memory_size write restarts the table as one free segment
            if (i_cfg_we && i_cfg_index == CFG_MEM_SIZE) begin
                r_msize <= i_cfg_data;
                r_cnt   <= CW'(1);
                r_init  <= 1'b1;
            end else begin
                r_cnt   <= n_cnt;
                r_init  <= n_init;
            end
            if (i_cfg_we && i_cfg_index == CFG_POLICY) r_pol <= i_cfg_data[1:0];
        end
        r_req <= n_req; r_i <= n_i; r_found <= n_found; r_pick <= n_pick;
        r_pe <= n_pe; r_nx <= n_nx; r_nxok <= n_nxok; r_mgn <= n_mgn;
        r_sh <= n_sh; r_up <= n_up; r_end <= n_end; r_rsp <= n_rsp;
    end

    logic [IW-1:0] rix;   // index of data in rd during scan
    logic          fits, better;
    logic [16:0]   msum;
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_req = r_req; n_i = r_i;
        n_found = r_found; n_pick = r_pick; n_pe = r_pe; n_nx = r_nx;
        n_nxok = r_nxok; n_mgn = r_mgn; n_sh = r_sh; n_up = r_up;
        n_end = r_end; n_rsp = r_rsp; n_done = 1'b0; n_init = r_init;
        we = 1'b0; waddr = '0; wdata = r_pe; raddr = r_i[IW-1:0];
        rix = IW'(r_i - CW'(1));
        fits = 1'b0; better = 1'b0; msum = '0;
        unique case (r_state)
            S_IDLE: begin
                raddr = '0;
                if (start) begin
                    n_req = i_req; n_i = CW'(1); n_found = 1'b0; n_pick = '0;
                    n_state = S_SCAN;
                end
            end
            // rd holds entry r_i-1; read entry r_i
            S_SCAN: begin
                if (r_req.req_type == REQ_ALLOC) begin
                    fits = !rd.used && rd.len >= r_req.request_size &&
                           r_req.request_size != 16'd0;
                    better = !r_found ||
                             (r_pol == POL_BEST  && rd.len < r_pe.len) ||
                             (r_pol == POL_WORST && rd.len > r_pe.len);
                    if (fits && better) begin
                        n_found = 1'b1; n_pick = rix; n_pe = rd;
                    end
                    if ((fits && r_pol != POL_BEST && r_pol != POL_WORST) ||
                        r_i >= r_cnt) n_state = S_DECIDE;
                end else begin
                    if (rd.used && rd.owner == r_req.process_id) begin
                        n_found = 1'b1; n_pick = rix; n_pe = rd;
                        n_state = S_DECIDE;
                    end else if (r_i >= r_cnt) n_state = S_DECIDE;
                end
                n_i = r_i + CW'(1);
            end
            S_DECIDE: begin
                if (!r_found) begin
                    n_rsp = '{status: (r_req.req_type == REQ_ALLOC) ? ST_NO_FIT
                              : ST_NO_OWNR, start_address: 16'd0, segment_length: 16'd0};
                    n_state = S_FINISH;
                end else if (r_req.req_type == REQ_ALLOC) begin
                    if (r_pe.len != r_req.request_size && r_cnt >= MaxCnt) begin
                        n_rsp = '{ST_NO_FIT, 16'd0, 16'd0};
                        n_state = S_FINISH;
                    end else begin
                        n_rsp = '{ST_DONE, r_pe.start, r_req.request_size};
                        we = 1'b1; waddr = r_pick;
                        wdata = '{r_pe.start, r_req.request_size, 1'b1,
                                  r_req.process_id};
                        if (r_pick == '0) n_init = 1'b0;
                        if (r_pe.len != r_req.request_size) begin
                            // open gap at pick+1, moving entries up from the top
                            n_sh = '{r_pe.start + r_req.request_size,
                                     r_pe.len - r_req.request_size, 1'b0, 8'd0};
                            n_up = 1'b1; n_i = r_cnt; n_end = CW'(r_pick) + CW'(1);
                            n_cnt = r_cnt + CW'(1);
                            n_state = S_SHIFT_RD;
                        end else n_state = S_FINISH;
                    end
                end else begin
                    n_pe.used = 1'b0; n_pe.owner = 8'd0;
                    n_mgn = 1'b0; n_nxok = 1'b0;
                    raddr = IW'(CW'(r_pick) + CW'(1));
                    n_state = S_RD_NEXT;
                end
            end
            S_RD_NEXT: begin
                if (CW'(r_pick) + CW'(1) < r_cnt && !rd.used) begin
                    msum = {1'b0, r_pe.len} + {1'b0, rd.len};
                    n_pe.len = msum[15:0]; n_mgn = 1'b1;
                end
                raddr = r_pick - IW'(1);
                n_state = S_RD_PREV;
            end
            S_RD_PREV: begin
                n_nx = rd;  // predecessor
                n_nxok = (r_pick != '0) && !rd.used;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                we = 1'b1;
                if (r_nxok) begin
                    msum = {1'b0, r_nx.len} + {1'b0, r_pe.len};
                    waddr = r_pick - IW'(1);
                    wdata = '{r_nx.start, msum[15:0], 1'b0, r_nx.owner};
                    n_rsp = '{ST_DONE, r_nx.start, msum[15:0]};
                    if (r_pick - IW'(1) == '0) n_init = 1'b0;
                end else begin
                    waddr = r_pick;
                    wdata = r_pe;
                    n_rsp = '{ST_DONE, r_pe.start, r_pe.len};
                    if (r_pick == '0) n_init = 1'b0;
                end
                // remove 1 or 2 entries by moving later ones down
                n_up = 1'b0;
                n_i = CW'(r_pick) + (r_mgn ? CW'(2) : CW'(1));
                n_end = r_cnt;
                n_sh = '0;
                if (r_mgn || r_nxok) begin
                    n_cnt = r_cnt - ((r_mgn && r_nxok) ? CW'(2) : CW'(1));
                    n_state = S_SHIFT_RD;
                end else n_state = S_FINISH;
            end
            // up: copy i-1 -> i for i = cnt downto end+1, then write end.
            // down: copy i -> i-d for i up to old count.
            S_SHIFT_RD: begin
                if (r_up) begin
                    if (r_i == r_end) begin
                        we = 1'b1; waddr = r_end[IW-1:0]; wdata = r_sh;
                        n_state = S_FINISH;
                    end else begin
                        raddr = IW'(r_i - CW'(1));
                        n_state = S_SHIFT_WR;
                    end
                end else begin
                    if (r_i >= r_end) n_state = S_FINISH;
                    else begin
                        raddr = r_i[IW-1:0];
                        n_state = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR: begin
                we = 1'b1; wdata = rd;
                if (rd0) n_init = 1'b0;
                if (r_up) begin
                    waddr = r_i[IW-1:0];
                    n_i = r_i - CW'(1);
                end else begin
                    waddr = IW'(r_i - ((r_mgn && r_nxok) ? CW'(2) : CW'(1)));
                    n_i = r_i + CW'(1);
                end
                n_state = S_SHIFT_RD;
            end
            S_FINISH: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
